// ===== rtl/lpm_pkg.sv =====
package lpm_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 6;
  localparam int unsigned PortW = 7;

  localparam logic [LenW-1:0] MaxLen = 6'd32;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } req_op_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,
    DP_ACCEPT,
    DP_L_ROOT,
    DP_L_NODE,
    DP_S_CHK,
    DP_S_WR,
    DP_T_ROOT,
    DP_T_LOAD,
    DP_T_STEP,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } lpm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_lookup;
    logic in_default;
    logic in_short;
    logic slot_zero;
    logic pool_full;
    logic slot_last;
    logic node_end;
    logic step_end;
    logic child_zero;
    logic out_busy;
  } lpm_stat_t;

endpackage

// ===== rtl/lpm_if.sv =====
interface lpm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [lpm_pkg::AddrW-1:0]   address;
  logic [lpm_pkg::LenW-1:0]    prefix_len;
  logic [lpm_pkg::PortW-1:0]   out_port_in;

  modport source (output valid, op, address, prefix_len, out_port_in, input ready);
  modport sink   (input valid, op, address, prefix_len, out_port_in, output ready);
endinterface

interface lpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpm_pkg::PortW-1:0]   port;
  logic                        matched;
  logic                        pool_full;

  modport source (output valid, port, matched, pool_full, input ready);
  modport sink   (input valid, port, matched, pool_full, output ready);
endinterface

// ===== rtl/lpm_ram.sv =====
module lpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/lpm_ctrl.sv =====
module lpm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lpm_pkg::lpm_stat_t stat_i,
  output lpm_pkg::lpm_cmd_t  cmd_o
);
  import lpm_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_L_ROOT = 10'b00_0000_0100,
    ST_L_NODE = 10'b00_0000_1000,
    ST_S_CHK  = 10'b00_0001_0000,
    ST_S_WR   = 10'b00_0010_0000,
    ST_T_ROOT = 10'b00_0100_0000,
    ST_T_LOAD = 10'b00_1000_0000,
    ST_T_STEP = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = DP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_ACCEPT;
          if (stat_i.in_lookup) begin
            state_d = ST_L_ROOT;
          end else if (stat_i.in_default) begin
            state_d = ST_DONE;
          end else if (stat_i.in_short) begin
            state_d = ST_S_CHK;
          end else begin
            state_d = ST_T_ROOT;
          end
        end
      end
      ST_L_ROOT: begin
        cmd_o.op = DP_L_ROOT;
        state_d  = stat_i.slot_zero ? ST_DONE : ST_L_NODE;
      end
      ST_L_NODE: begin
        cmd_o.op = DP_L_NODE;
        if (stat_i.node_end) begin
          state_d = ST_DONE;
        end
      end
      ST_S_CHK: begin
        cmd_o.op = DP_S_CHK;
        if (!stat_i.slot_zero) begin
          state_d = ST_S_WR;
        end else if (stat_i.pool_full || stat_i.slot_last) begin
          state_d = ST_DONE;
        end
      end
      ST_S_WR: begin
        cmd_o.op = DP_S_WR;
        state_d  = stat_i.slot_last ? ST_DONE : ST_S_CHK;
      end
      ST_T_ROOT: begin
        cmd_o.op = DP_T_ROOT;
        if (!stat_i.slot_zero) begin
          state_d = ST_T_LOAD;
        end else begin
          state_d = stat_i.pool_full ? ST_DONE : ST_T_STEP;
        end
      end
      ST_T_LOAD: begin
        cmd_o.op = DP_T_LOAD;
        state_d  = ST_T_STEP;
      end
      ST_T_STEP: begin
        cmd_o.op = DP_T_STEP;
        if (stat_i.step_end) begin
          state_d = ST_DONE;
        end else if (!stat_i.child_zero) begin
          state_d = ST_T_LOAD;
        end else if (stat_i.pool_full) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = DP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/lpm_dp.sv =====
module lpm_dp #(
  parameter int unsigned DIRECT_INDEX_BITS = 16,
  parameter int unsigned POOL_NODES        = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_i,
  input  logic [lpm_pkg::AddrW-1:0]  address_i,
  input  logic [lpm_pkg::LenW-1:0]   prefix_len_i,
  input  logic [lpm_pkg::PortW-1:0]  out_port_in_i,
  input  lpm_pkg::lpm_cmd_t          cmd_i,
  output lpm_pkg::lpm_stat_t         stat_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [lpm_pkg::PortW-1:0]  port_o,
  output logic                       matched_o,
  output logic                       pool_full_o
);
  import lpm_pkg::*;

  localparam int unsigned Dib    = DIRECT_INDEX_BITS;
  localparam int unsigned SlotN  = 1 << Dib;
  localparam int unsigned PtrW   = $clog2(POOL_NODES + 1);
  localparam int unsigned NfW    = $clog2(POOL_NODES + 2);
  localparam int unsigned NodeAw = $clog2(POOL_NODES);
  localparam int unsigned NodeW  = 1 + PortW + 2 * PtrW;
  localparam logic [LenW-1:0] DirLen = LenW'(Dib);
  localparam logic [NfW-1:0]  PoolLimit = NfW'(POOL_NODES);

  function automatic logic [NodeAw-1:0] ptr2a(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] m;
    m = p - PtrW'(1);
    return m[NodeAw-1:0];
  endfunction

  // Memory ports.
  logic              s_we, s_re, n_we, n_re;
  logic [Dib-1:0]    s_waddr, s_raddr;
  logic [PtrW-1:0]   s_wdata, s_rdata;
  logic [NodeAw-1:0] n_waddr, n_raddr;
  logic [NodeW-1:0]  n_wdata, n_rdata;

  // Control registers.
  logic [Dib-1:0]    clr_q, clr_d;
  logic [NfW-1:0]    nf_q, nf_d;
  logic [7:0]        dflt_q, dflt_d;
  logic              out_valid_q, out_valid_d;

  // Working registers.
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [PortW-1:0]  pin_q, pin_d;
  logic              op_q, op_d;
  logic [Dib-1:0]    cur_q, cur_d, end_q, end_d;
  logic [PtrW-1:0]   node_q, node_d;
  logic [NodeW-1:0]  nw_q, nw_d;
  logic [LenW-1:0]   i_q, i_d;
  logic [7:0]        best_q, best_d;
  logic              fail_q, fail_d;
  logic [PortW-1:0]  port_q, port_d;
  logic              matched_q, matched_d, pfull_q, pfull_d;

  logic [LenW-1:0]   in_len;
  logic [Dib-1:0]    in_top, keep_low, in_start;
  logic              nd_valid;
  logic [PortW-1:0]  nd_port;
  logic [PtrW-1:0]   nd_left, nd_right, nw_left, nw_right, l_next, t_child, new_ptr;
  logic              cur_bit, full;

  lpm_ram #(.Width(PtrW), .Depth(SlotN)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .re_i   (s_re),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  lpm_ram #(.Width(NodeW), .Depth(POOL_NODES)) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(n_waddr),
    .wdata_i(n_wdata),
    .re_i   (n_re),
    .raddr_i(n_raddr),
    .rdata_o(n_rdata)
  );

  assign in_len   = (prefix_len_i > MaxLen) ? MaxLen : prefix_len_i;
  assign in_top   = address_i[AddrW-1 -: Dib];
  // Low slot bits that a short prefix leaves free; the covered slots span them.
  assign keep_low = {Dib{1'b1}} >> in_len;
  assign in_start = in_top & ~keep_low;

  assign nd_valid = n_rdata[NodeW-1];
  assign nd_port  = n_rdata[NodeW-2 -: PortW];
  assign nd_left  = n_rdata[2*PtrW-1 -: PtrW];
  assign nd_right = n_rdata[PtrW-1:0];
  assign nw_left  = nw_q[2*PtrW-1 -: PtrW];
  assign nw_right = nw_q[PtrW-1:0];

  assign cur_bit  = addr_q[5'(6'd31 - i_q)];
  assign l_next   = cur_bit ? nd_right : nd_left;
  assign t_child  = cur_bit ? nw_right : nw_left;
  assign full     = nf_q > PoolLimit;
  assign new_ptr  = nf_q[PtrW-1:0];

  always_comb begin
    stat_o.clr_last   = (clr_q == {Dib{1'b1}});
    stat_o.in_lookup  = (op_i == OP_LOOKUP);
    stat_o.in_default = (in_len == '0);
    stat_o.in_short   = (in_len <= DirLen);
    stat_o.slot_zero  = (s_rdata == '0);
    stat_o.pool_full  = full;
    stat_o.slot_last  = (cur_q == end_q);
    stat_o.node_end   = (i_q == MaxLen) || (l_next == '0);
    stat_o.step_end   = (i_q == len_q);
    stat_o.child_zero = (t_child == '0);
    stat_o.out_busy   = out_valid_q & ~out_ready_i;
  end

  always_comb begin
    clr_d = clr_q;   nf_d = nf_q;   dflt_d = dflt_q;
    addr_d = addr_q; len_d = len_q; pin_d = pin_q; op_d = op_q;
    cur_d = cur_q;   end_d = end_q; node_d = node_q; nw_d = nw_q;
    i_d = i_q;       best_d = best_q; fail_d = fail_q;
    port_d = port_q; matched_d = matched_q; pfull_d = pfull_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_re = 1'b0; n_raddr = '0;

    case (cmd_i.op)
      DP_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_q;
        clr_d   = clr_q + Dib'(1);
      end
      DP_ACCEPT: begin
        addr_d = address_i;
        len_d  = in_len;
        pin_d  = out_port_in_i;
        op_d   = op_i;
        fail_d = 1'b0;
        best_d = dflt_q;
        i_d    = DirLen;
        cur_d  = (op_i == OP_INSERT) ? in_start : in_top;
        end_d  = in_start | keep_low;
        s_re    = 1'b1;
        s_raddr = cur_d;
        if (op_i == OP_INSERT && in_len == '0) begin
          dflt_d = {1'b1, out_port_in_i};
        end
      end
      DP_L_ROOT: begin
        if (s_rdata != '0) begin
          n_re    = 1'b1;
          n_raddr = ptr2a(s_rdata);
          node_d  = s_rdata;
        end
      end
      DP_L_NODE: begin
        if (nd_valid) begin
          best_d = {1'b1, nd_port};
        end
        if (!stat_o.node_end) begin
          n_re    = 1'b1;
          n_raddr = ptr2a(l_next);
          node_d  = l_next;
          i_d     = i_q + LenW'(1);
        end
      end
      DP_S_CHK: begin
        if (s_rdata == '0) begin
          if (full) begin
            fail_d = 1'b1;
          end else begin
            nf_d    = nf_q + NfW'(1);
            s_we    = 1'b1;
            s_waddr = cur_q;
            s_wdata = new_ptr;
            n_we    = 1'b1;
            n_waddr = ptr2a(new_ptr);
            n_wdata = {1'b1, pin_q, {(2*PtrW){1'b0}}};
            if (cur_q != end_q) begin
              cur_d   = cur_q + Dib'(1);
              s_re    = 1'b1;
              s_raddr = cur_d;
            end
          end
        end else begin
          n_re    = 1'b1;
          n_raddr = ptr2a(s_rdata);
          node_d  = s_rdata;
        end
      end
      DP_S_WR: begin
        n_we    = 1'b1;
        n_waddr = ptr2a(node_q);
        n_wdata = {1'b1, pin_q, nd_left, nd_right};
        if (cur_q != end_q) begin
          cur_d   = cur_q + Dib'(1);
          s_re    = 1'b1;
          s_raddr = cur_d;
        end
      end
      DP_T_ROOT: begin
        if (s_rdata == '0) begin
          if (full) begin
            fail_d = 1'b1;
          end else begin
            // The fresh root is written later, on the way down or at the stop.
            nf_d    = nf_q + NfW'(1);
            s_we    = 1'b1;
            s_waddr = cur_q;
            s_wdata = new_ptr;
            node_d  = new_ptr;
            nw_d    = '0;
          end
        end else begin
          n_re    = 1'b1;
          n_raddr = ptr2a(s_rdata);
          node_d  = s_rdata;
        end
      end
      DP_T_LOAD: begin
        nw_d = n_rdata;
      end
      DP_T_STEP: begin
        n_waddr = ptr2a(node_q);
        if (i_q == len_q) begin
          n_we    = 1'b1;
          n_wdata = {1'b1, pin_q, nw_left, nw_right};
        end else if (t_child != '0) begin
          n_re    = 1'b1;
          n_raddr = ptr2a(t_child);
          node_d  = t_child;
          i_d     = i_q + LenW'(1);
        end else if (full) begin
          // Write the current node back so that a fresh node reads as empty.
          fail_d  = 1'b1;
          n_we    = 1'b1;
          n_wdata = nw_q;
        end else begin
          nf_d    = nf_q + NfW'(1);
          n_we    = 1'b1;
          n_wdata = cur_bit ? {nw_q[NodeW-1 -: 8], nw_left, new_ptr}
                            : {nw_q[NodeW-1 -: 8], new_ptr, nw_right};
          node_d  = new_ptr;
          nw_d    = '0;
          i_d     = i_q + LenW'(1);
        end
      end
      DP_EMIT: begin
        out_valid_d = 1'b1;
        if (op_q == OP_LOOKUP) begin
          matched_d = best_q[7];
          port_d    = best_q[7] ? best_q[PortW-1:0] : '0;
          pfull_d   = 1'b0;
        end else begin
          matched_d = 1'b0;
          port_d    = '0;
          pfull_d   = fail_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      nf_q        <= NfW'(1);
      dflt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      nf_q        <= nf_d;
      dflt_q      <= dflt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    len_q     <= len_d;
    pin_q     <= pin_d;
    op_q      <= op_d;
    cur_q     <= cur_d;
    end_q     <= end_d;
    node_q    <= node_d;
    nw_q      <= nw_d;
    i_q       <= i_d;
    best_q    <= best_d;
    fail_q    <= fail_d;
    port_q    <= port_d;
    matched_q <= matched_d;
    pfull_q   <= pfull_d;
  end

  assign out_valid_o = out_valid_q;
  assign port_o      = port_q;
  assign matched_o   = matched_q;
  assign pool_full_o = pfull_q;

endmodule

// ===== rtl/longest_prefix_match_lookup_top.sv =====
// Lookup: reads the slot, then the root node and k trie nodes beyond it
// (k at most 32 - DIRECT_INDEX_BITS), with one node RAM read per level.
// Insert of a long prefix walks the trie one level at a time; a short prefix of length L
// visits up to 2^(DIRECT_INDEX_BITS - L) slots, fewer if the pool runs out. One transaction at a time.
// After reset a clearing pass writes zero to all 2^DIRECT_INDEX_BITS slots, one per
// cycle, before the first transaction is accepted.
module longest_prefix_match_lookup_top #(
  parameter int unsigned DIRECT_INDEX_BITS = 16,
  parameter int unsigned POOL_NODES        = 4096
) (
  input logic        clk_i,
  input logic        rst_ni,
  lpm_in_if.sink     req_i,
  lpm_out_if.source  rsp_o
);
  import lpm_pkg::*;

  lpm_cmd_t  cmd;
  lpm_stat_t stat;

  lpm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(req_i.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lpm_dp #(
    .DIRECT_INDEX_BITS(DIRECT_INDEX_BITS),
    .POOL_NODES       (POOL_NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (req_i.op),
    .address_i    (req_i.address),
    .prefix_len_i (req_i.prefix_len),
    .out_port_in_i(req_i.out_port_in),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .port_o       (rsp_o.port),
    .matched_o    (rsp_o.matched),
    .pool_full_o  (rsp_o.pool_full)
  );

endmodule

// ===== rtl/lpm_checker.sv =====
module lpm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [lpm_pkg::PortW-1:0] port_i,
  input logic                      matched_i,
  input logic                      pool_full_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(port_i) && $stable(matched_i)
      && $stable(pool_full_i))
    else $error("result changed while stalled");

  // A matched result never carries the exhaustion flag.
  a_match_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(matched_i && pool_full_i))
    else $error("matched and pool_full both set");

  // Without a match the port reads zero.
  a_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !matched_i |-> port_i == '0)
    else $error("port nonzero without a match");

  // One transaction is worked on at a time.
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

endmodule

bind longest_prefix_match_lookup_top lpm_checker u_lpm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (req_i.valid),
  .in_ready_i (req_i.ready),
  .out_valid_i(rsp_o.valid),
  .out_ready_i(rsp_o.ready),
  .port_i     (rsp_o.port),
  .matched_i  (rsp_o.matched),
  .pool_full_i(rsp_o.pool_full)
);
